>>> design/msq_pkg.sv
// ----------------------------------------------------------------------------
// msq_pkg
// Types, constants and table functions shared by the contour extractor.
// ----------------------------------------------------------------------------
package msq_pkg;

    localparam int XW       = 48;
    localparam int LIM_W    = 13;
    localparam int PITCH_W  = 31;
    localparam int DIV_LAST = 30;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_CLASS,
        ST_EDGE,
        ST_DIV,
        ST_ROUND,
        ST_POINT,
        ST_OUT
    } state_t;

    localparam logic [1:0] EDGE_TOP    = 2'd0;
    localparam logic [1:0] EDGE_RIGHT  = 2'd1;
    localparam logic [1:0] EDGE_BOTTOM = 2'd2;
    localparam logic [1:0] EDGE_LEFT   = 2'd3;

    localparam logic [2:0] REG_COLUMNS = 3'd0;
    localparam logic [2:0] REG_ROWS    = 3'd1;
    localparam logic [2:0] REG_THRESH  = 3'd2;
    localparam logic [2:0] REG_ORIG_X  = 3'd3;
    localparam logic [2:0] REG_ORIG_Y  = 3'd4;
    localparam logic [2:0] REG_PITCH   = 3'd5;

    function automatic logic [1:0] pair_count(input logic [3:0] ci);
        logic [1:0] n;
        case (ci)
            4'd0, 4'd15: n = 2'd0;
            4'd5, 4'd10: n = 2'd2;
            default:     n = 2'd1;
        endcase
        return n;
    endfunction

    function automatic logic [1:0] seg_edge(input logic [3:0] ci, input logic k,
                                            input logic j, input logic mean_low);
        logic [7:0] pairs;
        logic [3:0] pk;
        case (ci)
            4'd1:  pairs = {EDGE_LEFT, EDGE_BOTTOM, 4'd0};
            4'd2:  pairs = {EDGE_BOTTOM, EDGE_RIGHT, 4'd0};
            4'd3:  pairs = {EDGE_LEFT, EDGE_RIGHT, 4'd0};
            4'd4:  pairs = {EDGE_RIGHT, EDGE_TOP, 4'd0};
            4'd5:  pairs = mean_low ? {EDGE_LEFT, EDGE_BOTTOM, EDGE_RIGHT, EDGE_TOP}
                                    : {EDGE_LEFT, EDGE_TOP, EDGE_RIGHT, EDGE_BOTTOM};
            4'd6:  pairs = {EDGE_BOTTOM, EDGE_TOP, 4'd0};
            4'd7:  pairs = {EDGE_LEFT, EDGE_TOP, 4'd0};
            4'd8:  pairs = {EDGE_TOP, EDGE_LEFT, 4'd0};
            4'd9:  pairs = {EDGE_TOP, EDGE_BOTTOM, 4'd0};
            4'd10: pairs = mean_low ? {EDGE_TOP, EDGE_LEFT, EDGE_BOTTOM, EDGE_RIGHT}
                                    : {EDGE_TOP, EDGE_RIGHT, EDGE_BOTTOM, EDGE_LEFT};
            4'd11: pairs = {EDGE_TOP, EDGE_RIGHT, 4'd0};
            4'd12: pairs = {EDGE_RIGHT, EDGE_LEFT, 4'd0};
            4'd13: pairs = {EDGE_RIGHT, EDGE_BOTTOM, 4'd0};
            4'd14: pairs = {EDGE_BOTTOM, EDGE_LEFT, 4'd0};
            default: pairs = 8'd0;
        endcase
        pk = k ? pairs[3:0] : pairs[7:4];
        return j ? pk[1:0] : pk[3:2];
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [XW-1:0] v);
        logic signed [31:0] r;
        if (v > XW'(64'sd2147483647)) begin
            r = 32'sh7FFFFFFF;
        end else if (v < -XW'(64'sd2147483648)) begin
            r = 32'sh80000000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

>>> design/msq_ram.sv
// ----------------------------------------------------------------------------
// msq_ram
// Simple dual-port RAM with one write port and a registered read port.
// ----------------------------------------------------------------------------
module msq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

>>> design/marching_squares_contour.sv
// ----------------------------------------------------------------------------
// marching_squares_contour
// Streaming marching-squares isoline extractor with saddle resolution by the
// cell mean; the previous grid row is held in a line store RAM.
// ----------------------------------------------------------------------------
// A sample without segments passes through transfer, line store read and classification.
// Each segment endpoint adds an edge set-up and a point step, plus the bit-serial
// divider (31 steps, one bit of cell_pitch per cycle) and a rounding step when it
// needs them; each segment adds an output transfer that waits for m_ready.
// Reset is synchronous and active low; it clears the counters, the left and upper-left
// samples and the configuration registers; the line store is not cleared.
module marching_squares_contour #(
    parameter int MAX_COLUMNS = 1024,
    parameter int MAX_ROWS    = 1024
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [4:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic signed [31:0] s_sample_value,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [31:0] m_start_x,
    output logic signed [31:0] m_start_y,
    output logic signed [31:0] m_end_x,
    output logic signed [31:0] m_end_y,
    output logic [20:0]        m_segment_number,
    output logic               m_last_of_item
);

    localparam int CW = $clog2(MAX_COLUMNS);
    localparam int RW = $clog2(MAX_ROWS);
    localparam int XW = msq_pkg::XW;
    localparam int LW = msq_pkg::LIM_W;

    msq_pkg::state_t state_reg, state_next;

    logic [10:0]        cols_reg, rows_reg;
    logic signed [31:0] thr_reg, ox_reg, oy_reg;
    logic [30:0]        pitch_reg;

    logic [CW-1:0]      col_reg;
    logic [RW-1:0]      row_reg;
    logic [21:0]        seg_cnt_reg;
    logic signed [31:0] left_reg, ul_reg, cur_reg;
    logic signed [31:0] tl_reg, tr_reg, br_reg, bl_reg;
    logic               active_reg, frame_end_reg;
    logic [CW+30:0]     mulx_reg;
    logic [RW+30:0]     muly_reg;
    logic signed [XW-1:0] x0_reg, y0_reg;
    logic [3:0]         ci_reg;
    logic               mean_low_reg;
    logic [1:0]         np_reg;
    logic               k_reg, j_reg;
    logic [1:0]         edge_reg;
    logic [32:0]        an_reg, ad_reg, rem_reg;
    logic [30:0]        quo_reg, off_reg;
    logic [4:0]         bit_reg;
    logic signed [31:0] sx_reg, sy_reg;
    logic signed [31:0] ox_out_reg, oy_out_reg, ex_out_reg, ey_out_reg;
    logic [20:0]        num_out_reg;
    logic               last_out_reg;

    logic [31:0]        ram_rdata;
    logic               s_fire, m_fire, cfg_we;
    logic [LW-1:0]      cols_eff, rows_eff, col_inc, row_inc;
    logic               col_wrap, row_wrap;

    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite;
    assign s_ready = (state_reg == msq_pkg::ST_IDLE);
    assign m_valid = (state_reg == msq_pkg::ST_OUT);
    assign s_fire = s_valid && s_ready;
    assign m_fire = m_valid && m_ready;

    assign m_start_x        = ox_out_reg;
    assign m_start_y        = oy_out_reg;
    assign m_end_x          = ex_out_reg;
    assign m_end_y          = ey_out_reg;
    assign m_segment_number = num_out_reg;
    assign m_last_of_item   = last_out_reg;

    always_comb begin
        case (paddr[4:2])
            msq_pkg::REG_COLUMNS: prdata = {21'd0, cols_reg};
            msq_pkg::REG_ROWS:    prdata = {21'd0, rows_reg};
            msq_pkg::REG_THRESH:  prdata = thr_reg;
            msq_pkg::REG_ORIG_X:  prdata = ox_reg;
            msq_pkg::REG_ORIG_Y:  prdata = oy_reg;
            msq_pkg::REG_PITCH:   prdata = {1'b0, pitch_reg};
            default:              prdata = 32'd0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cols_reg  <= 11'd1024;
            rows_reg  <= 11'd1024;
            thr_reg   <= 32'sd65536;
            ox_reg    <= 32'sd0;
            oy_reg    <= 32'sd0;
            pitch_reg <= 31'd65536;
        end else if (cfg_we) begin
            case (paddr[4:2])
                msq_pkg::REG_COLUMNS: cols_reg  <= pwdata[10:0];
                msq_pkg::REG_ROWS:    rows_reg  <= pwdata[10:0];
                msq_pkg::REG_THRESH:  thr_reg   <= pwdata;
                msq_pkg::REG_ORIG_X:  ox_reg    <= pwdata;
                msq_pkg::REG_ORIG_Y:  oy_reg    <= pwdata;
                msq_pkg::REG_PITCH:   pitch_reg <= pwdata[30:0];
                default: ;
            endcase
        end
    end

    // Grid size clamped to the supported range.
    always_comb begin
        if (cols_reg < 11'd2) begin
            cols_eff = LW'(2);
        end else if (LW'(cols_reg) > LW'(MAX_COLUMNS)) begin
            cols_eff = LW'(MAX_COLUMNS);
        end else begin
            cols_eff = LW'(cols_reg);
        end
        if (rows_reg < 11'd2) begin
            rows_eff = LW'(2);
        end else if (LW'(rows_reg) > LW'(MAX_ROWS)) begin
            rows_eff = LW'(MAX_ROWS);
        end else begin
            rows_eff = LW'(rows_reg);
        end
        col_inc  = LW'(col_reg) + LW'(1);
        row_inc  = LW'(row_reg) + LW'(1);
        col_wrap = (col_inc >= cols_eff);
        row_wrap = (row_inc >= rows_eff);
    end

    msq_ram #(
        .WIDTH (32),
        .DEPTH (MAX_COLUMNS)
    ) u_line_store (
        .aclk  (aclk),
        .we    (state_reg == msq_pkg::ST_READ),
        .waddr (col_reg),
        .wdata (cur_reg),
        .re    (s_fire),
        .raddr (col_reg),
        .rdata (ram_rdata)
    );

    // Cell classification and saddle mean.
    logic signed [33:0] corner_sum;
    logic signed [31:0] cell_mean;
    logic [3:0]         ci_comb;

    always_comb begin
        ci_comb = {tl_reg >= thr_reg, tr_reg >= thr_reg,
                   br_reg >= thr_reg, bl_reg >= thr_reg};
        corner_sum = 34'(tl_reg) + 34'(tr_reg) + 34'(br_reg) + 34'(bl_reg);
        cell_mean  = 32'(corner_sum >>> 2);
    end

    // Edge set-up for one endpoint.
    logic [1:0]         edge_comb;
    logic signed [31:0] v0, v1;
    logic signed [32:0] diff_d, diff_n;
    logic [32:0]        abs_d, abs_n;

    always_comb begin
        edge_comb = msq_pkg::seg_edge(ci_reg, k_reg, j_reg, mean_low_reg);
        case (edge_comb)
            msq_pkg::EDGE_TOP:    begin v0 = tl_reg; v1 = tr_reg; end
            msq_pkg::EDGE_RIGHT:  begin v0 = tr_reg; v1 = br_reg; end
            msq_pkg::EDGE_BOTTOM: begin v0 = bl_reg; v1 = br_reg; end
            default:              begin v0 = tl_reg; v1 = bl_reg; end
        endcase
        diff_d = 33'(v1) - 33'(v0);
        diff_n = 33'(thr_reg) - 33'(v0);
        abs_d  = diff_d[32] ? 33'(-diff_d) : 33'(diff_d);
        abs_n  = diff_n[32] ? 33'(-diff_n) : 33'(diff_n);
    end

    // One quotient bit per cycle: remainder doubles and takes an when the pitch bit is set.
    logic [34:0] div_r2, div_rn;
    logic [1:0]  div_qd;
    logic [33:0] round_r;

    always_comb begin
        div_r2 = {1'b0, rem_reg, 1'b0} + (pitch_reg[bit_reg] ? {2'b0, an_reg} : 35'd0);
        if (div_r2 >= {1'b0, ad_reg, 1'b0}) begin
            div_rn = div_r2 - {1'b0, ad_reg, 1'b0};
            div_qd = 2'd2;
        end else if (div_r2 >= {2'b0, ad_reg}) begin
            div_rn = div_r2 - {2'b0, ad_reg};
            div_qd = 2'd1;
        end else begin
            div_rn = div_r2;
            div_qd = 2'd0;
        end
        round_r = {1'b0, rem_reg} + {2'b0, ad_reg[32:1]};
    end

    // Endpoint position from the cell corner and the edge offset.
    logic signed [XW-1:0] off_w, pitch_w, px, py;
    logic signed [31:0]   px_sat, py_sat;

    always_comb begin
        off_w   = XW'(off_reg);
        pitch_w = XW'(pitch_reg);
        case (edge_reg)
            msq_pkg::EDGE_TOP:    begin px = x0_reg + off_w;   py = y0_reg;           end
            msq_pkg::EDGE_RIGHT:  begin px = x0_reg + pitch_w; py = y0_reg + off_w;   end
            msq_pkg::EDGE_BOTTOM: begin px = x0_reg + off_w;   py = y0_reg + pitch_w; end
            default:              begin px = x0_reg;           py = y0_reg + off_w;   end
        endcase
        px_sat = msq_pkg::sat32(px);
        py_sat = msq_pkg::sat32(py);
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            msq_pkg::ST_IDLE: begin
                if (s_fire) begin
                    state_next = msq_pkg::ST_READ;
                end
            end
            msq_pkg::ST_READ: state_next = msq_pkg::ST_CLASS;
            msq_pkg::ST_CLASS: begin
                if (active_reg && msq_pkg::pair_count(ci_comb) != 2'd0) begin
                    state_next = msq_pkg::ST_EDGE;
                end else begin
                    state_next = msq_pkg::ST_IDLE;
                end
            end
            msq_pkg::ST_EDGE: begin
                if (diff_d == 33'sd0 || (diff_n != 33'sd0 && diff_n[32] != diff_d[32])
                    || abs_n >= abs_d) begin
                    state_next = msq_pkg::ST_POINT;
                end else begin
                    state_next = msq_pkg::ST_DIV;
                end
            end
            msq_pkg::ST_DIV: begin
                if (bit_reg == 5'd0) begin
                    state_next = msq_pkg::ST_ROUND;
                end
            end
            msq_pkg::ST_ROUND: state_next = msq_pkg::ST_POINT;
            msq_pkg::ST_POINT: begin
                if (j_reg) begin
                    state_next = msq_pkg::ST_OUT;
                end else begin
                    state_next = msq_pkg::ST_EDGE;
                end
            end
            msq_pkg::ST_OUT: begin
                if (m_fire) begin
                    if (last_out_reg) begin
                        state_next = msq_pkg::ST_IDLE;
                    end else begin
                        state_next = msq_pkg::ST_EDGE;
                    end
                end
            end
            default: state_next = msq_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= msq_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Control state: counters, held samples and loop indices.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg       <= '0;
            row_reg       <= '0;
            seg_cnt_reg   <= '0;
            left_reg      <= '0;
            ul_reg        <= '0;
            active_reg    <= 1'b0;
            frame_end_reg <= 1'b0;
            k_reg         <= 1'b0;
            j_reg         <= 1'b0;
            np_reg        <= '0;
        end else begin
            case (state_reg)
                msq_pkg::ST_READ: begin
                    ul_reg        <= ram_rdata;
                    left_reg      <= cur_reg;
                    active_reg    <= (row_reg != '0) && (col_reg != '0);
                    frame_end_reg <= col_wrap && row_wrap;
                    if (col_wrap) begin
                        col_reg <= '0;
                        if (row_wrap) begin
                            row_reg <= '0;
                        end else begin
                            row_reg <= row_reg + RW'(1);
                        end
                    end else begin
                        col_reg <= col_reg + CW'(1);
                    end
                end
                msq_pkg::ST_CLASS: begin
                    np_reg <= msq_pkg::pair_count(ci_comb);
                    k_reg  <= 1'b0;
                    j_reg  <= 1'b0;
                    if (!(active_reg && msq_pkg::pair_count(ci_comb) != 2'd0)
                        && frame_end_reg) begin
                        seg_cnt_reg <= '0;
                    end
                end
                msq_pkg::ST_POINT: begin
                    j_reg <= !j_reg;
                end
                msq_pkg::ST_OUT: begin
                    if (m_fire) begin
                        if (last_out_reg && frame_end_reg) begin
                            seg_cnt_reg <= '0;
                        end else begin
                            seg_cnt_reg <= seg_cnt_reg + 22'd1;
                        end
                        k_reg <= 1'b1;
                    end
                end
                default: ;
            endcase
        end
    end

    // Datapath registers.
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            cur_reg <= s_sample_value;
        end
        case (state_reg)
            msq_pkg::ST_READ: begin
                tl_reg   <= ul_reg;
                tr_reg   <= ram_rdata;
                br_reg   <= cur_reg;
                bl_reg   <= left_reg;
                mulx_reg <= (CW+31)'(col_reg - CW'(1)) * (CW+31)'(pitch_reg);
                muly_reg <= (RW+31)'(row_reg - RW'(1)) * (RW+31)'(pitch_reg);
            end
            msq_pkg::ST_CLASS: begin
                ci_reg       <= ci_comb;
                mean_low_reg <= (cell_mean < thr_reg);
                x0_reg       <= XW'(ox_reg) + XW'(mulx_reg);
                y0_reg       <= XW'(oy_reg) + XW'(muly_reg);
            end
            msq_pkg::ST_EDGE: begin
                edge_reg <= edge_comb;
                an_reg   <= abs_n;
                ad_reg   <= abs_d;
                rem_reg  <= '0;
                quo_reg  <= '0;
                bit_reg  <= 5'(msq_pkg::DIV_LAST);
                if (diff_d == 33'sd0) begin
                    off_reg <= {1'b0, pitch_reg[30:1]};
                end else if (diff_n != 33'sd0 && diff_n[32] != diff_d[32]) begin
                    off_reg <= '0;
                end else begin
                    off_reg <= pitch_reg;
                end
            end
            msq_pkg::ST_DIV: begin
                rem_reg <= div_rn[32:0];
                quo_reg <= {quo_reg[29:0], 1'b0} + 31'(div_qd);
                bit_reg <= bit_reg - 5'd1;
            end
            msq_pkg::ST_ROUND: begin
                off_reg <= (round_r >= {1'b0, ad_reg}) ? quo_reg + 31'd1 : quo_reg;
            end
            msq_pkg::ST_POINT: begin
                if (j_reg) begin
                    ox_out_reg   <= sx_reg;
                    oy_out_reg   <= sy_reg;
                    ex_out_reg   <= px_sat;
                    ey_out_reg   <= py_sat;
                    num_out_reg  <= seg_cnt_reg[20:0];
                    last_out_reg <= !(np_reg == 2'd2 && !k_reg);
                end else begin
                    sx_reg <= px_sat;
                    sy_reg <= py_sat;
                end
            end
            default: ;
        endcase
    end

    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_ready && m_valid))
        else $error("input and output transfers enabled together");

    a_offset_range: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == msq_pkg::ST_POINT |-> off_reg <= pitch_reg)
        else $error("edge offset beyond the pitch");

    a_rem_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == msq_pkg::ST_DIV |-> rem_reg < ad_reg)
        else $error("divider remainder out of range");

    a_last_returns: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_fire && m_last_of_item) |=> s_ready)
        else $error("block not ready after the final segment transfer");

endmodule

>>> sim/marching_squares_contour_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// marching_squares_contour_tb
// Streams grid frames into the contour extractor and compares every segment
// transfer against a cycle-free prediction of the expected line segments.
// ----------------------------------------------------------------------------
module marching_squares_contour_tb;

    typedef struct packed {
        logic signed [31:0] sx;
        logic signed [31:0] sy;
        logic signed [31:0] ex;
        logic signed [31:0] ey;
        logic [20:0]        num;
        logic               last;
    } segment_t;

    class contour_scoreboard;
        logic [10:0]  cols_reg, rows_reg;
        longint       thr, org_x, org_y, pitch;
        longint       line_store [1024];
        longint       left_val, upper_left_val;
        int unsigned  col_cnt, row_cnt, seg_cnt;
        segment_t     pending [$];
        int           errors;

        function void reset_state();
            cols_reg = 11'd1024; rows_reg = 11'd1024;
            thr = 65536; org_x = 0; org_y = 0; pitch = 65536;
            foreach (line_store[i]) line_store[i] = 0;
            left_val = 0; upper_left_val = 0;
            col_cnt = 0; row_cnt = 0; seg_cnt = 0;
            pending.delete();
            errors = 0;
        endfunction

        function void write_reg(logic [2:0] idx, logic [31:0] val);
            case (idx)
                msq_pkg::REG_COLUMNS: cols_reg = val[10:0];
                msq_pkg::REG_ROWS:    rows_reg = val[10:0];
                msq_pkg::REG_THRESH:  thr = longint'($signed(val));
                msq_pkg::REG_ORIG_X:  org_x = longint'($signed(val));
                msq_pkg::REG_ORIG_Y:  org_y = longint'($signed(val));
                msq_pkg::REG_PITCH:   pitch = longint'(val[30:0]);
                default: ;
            endcase
        endfunction

        function longint edge_offset(longint v0, longint v1);
            longint d, n;
            longint unsigned ad, an, p;
            d = v1 - v0;
            n = thr - v0;
            p = pitch;
            if (d == 0) return pitch >>> 1;
            if (n != 0 && ((n < 0) != (d < 0))) return 0;
            ad = (d < 0) ? -d : d;
            an = (n < 0) ? -n : n;
            if (an >= ad) return pitch;
            return longint'((an * p + (ad >> 1)) / ad);
        endfunction

        function void edge_point(logic [1:0] e, longint cv[4], longint x0, longint y0,
                                 output longint px, output longint py);
            case (e)
                msq_pkg::EDGE_TOP: begin
                    px = x0 + edge_offset(cv[0], cv[1]); py = y0;
                end
                msq_pkg::EDGE_RIGHT: begin
                    px = x0 + pitch; py = y0 + edge_offset(cv[1], cv[2]);
                end
                msq_pkg::EDGE_BOTTOM: begin
                    px = x0 + edge_offset(cv[3], cv[2]); py = y0 + pitch;
                end
                default: begin px = x0; py = y0 + edge_offset(cv[0], cv[3]); end
            endcase
        endfunction

        function logic signed [31:0] clip32(longint v);
            if (v > 64'sd2147483647) return 32'sh7FFFFFFF;
            if (v < -64'sd2147483648) return 32'sh80000000;
            return v[31:0];
        endfunction

        // Edge pair for segment k of a case; a low mean flips the saddle joins.
        function logic [3:0] crossing_edges(logic [3:0] ci, int k, bit mean_low);
            case (ci)
                4'd1:  return {msq_pkg::EDGE_LEFT, msq_pkg::EDGE_BOTTOM};
                4'd2:  return {msq_pkg::EDGE_BOTTOM, msq_pkg::EDGE_RIGHT};
                4'd3:  return {msq_pkg::EDGE_LEFT, msq_pkg::EDGE_RIGHT};
                4'd4:  return {msq_pkg::EDGE_RIGHT, msq_pkg::EDGE_TOP};
                4'd5:  begin
                    if (mean_low)
                        return (k == 0) ? {msq_pkg::EDGE_LEFT, msq_pkg::EDGE_BOTTOM}
                                        : {msq_pkg::EDGE_RIGHT, msq_pkg::EDGE_TOP};
                    return (k == 0) ? {msq_pkg::EDGE_LEFT, msq_pkg::EDGE_TOP}
                                    : {msq_pkg::EDGE_RIGHT, msq_pkg::EDGE_BOTTOM};
                end
                4'd6:  return {msq_pkg::EDGE_BOTTOM, msq_pkg::EDGE_TOP};
                4'd7:  return {msq_pkg::EDGE_LEFT, msq_pkg::EDGE_TOP};
                4'd8:  return {msq_pkg::EDGE_TOP, msq_pkg::EDGE_LEFT};
                4'd9:  return {msq_pkg::EDGE_TOP, msq_pkg::EDGE_BOTTOM};
                4'd10: begin
                    if (mean_low)
                        return (k == 0) ? {msq_pkg::EDGE_TOP, msq_pkg::EDGE_LEFT}
                                        : {msq_pkg::EDGE_BOTTOM, msq_pkg::EDGE_RIGHT};
                    return (k == 0) ? {msq_pkg::EDGE_TOP, msq_pkg::EDGE_RIGHT}
                                    : {msq_pkg::EDGE_BOTTOM, msq_pkg::EDGE_LEFT};
                end
                4'd11: return {msq_pkg::EDGE_TOP, msq_pkg::EDGE_RIGHT};
                4'd12: return {msq_pkg::EDGE_RIGHT, msq_pkg::EDGE_LEFT};
                4'd13: return {msq_pkg::EDGE_RIGHT, msq_pkg::EDGE_BOTTOM};
                4'd14: return {msq_pkg::EDGE_BOTTOM, msq_pkg::EDGE_LEFT};
                default: return 4'd0;
            endcase
        endfunction

        function void note_sample(logic signed [31:0] s);
            int unsigned cols, rows, col, nseg;
            longint cur, above, x0, y0, ax, ay, bx, by, sum;
            longint cv[4];
            logic [3:0] ci, pr;
            bit mean_low;
            segment_t seg;
            cols = (cols_reg < 2) ? 2 : ((cols_reg > 1024) ? 1024 : cols_reg);
            rows = (rows_reg < 2) ? 2 : ((rows_reg > 1024) ? 1024 : rows_reg);
            col = (col_cnt < 1024) ? col_cnt : 1023;
            cur = longint'(s);
            above = line_store[col];
            if (row_cnt >= 1 && col >= 1) begin
                cv[0] = upper_left_val; cv[1] = above; cv[2] = cur; cv[3] = left_val;
                ci = {cv[0] >= thr, cv[1] >= thr, cv[2] >= thr, cv[3] >= thr};
                nseg = (ci == 4'd0 || ci == 4'd15) ? 0 : ((ci == 4'd5 || ci == 4'd10) ? 2 : 1);
                sum = cv[0] + cv[1] + cv[2] + cv[3];
                mean_low = (sum >>> 2) < thr;
                x0 = org_x + longint'(col - 1) * pitch;
                y0 = org_y + longint'(row_cnt - 1) * pitch;
                for (int k = 0; k < nseg; k++) begin
                    pr = crossing_edges(ci, k, mean_low);
                    edge_point(pr[3:2], cv, x0, y0, ax, ay);
                    edge_point(pr[1:0], cv, x0, y0, bx, by);
                    seg.sx = clip32(ax); seg.sy = clip32(ay);
                    seg.ex = clip32(bx); seg.ey = clip32(by);
                    seg.num = seg_cnt[20:0];
                    seg.last = (k + 1 == nseg);
                    pending.push_back(seg);
                    seg_cnt = (seg_cnt + 1) & 32'h3FFFFF;
                end
            end
            upper_left_val = above;
            line_store[col] = cur;
            left_val = cur;
            if (col + 1 >= cols) begin
                col_cnt = 0;
                if (row_cnt + 1 >= rows) begin
                    row_cnt = 0;
                    seg_cnt = 0;
                end else begin
                    row_cnt++;
                end
            end else begin
                col_cnt = col + 1;
            end
        endfunction

        function void check_segment(segment_t got);
            segment_t want;
            if (pending.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("unexpected segment transfer: %p", got);
                return;
            end
            want = pending.pop_front();
            if (got !== want) begin
                errors++;
                if (errors <= 10)
                    $display("segment mismatch: expected %p, actual %p", want, got);
            end
        endfunction
    endclass

    logic               aclk;
    logic               aresetn;
    logic               psel, penable, pwrite;
    logic [4:0]         paddr;
    logic [31:0]        pwdata;
    logic [31:0]        prdata;
    logic               pready;
    logic               s_valid;
    logic               s_ready;
    logic signed [31:0] s_sample_value;
    logic               m_valid;
    logic               m_ready;
    logic signed [31:0] m_start_x, m_start_y, m_end_x, m_end_y;
    logic [20:0]        m_segment_number;
    logic               m_last_of_item;

    contour_scoreboard sb;
    int  send_idle_pct;
    int  recv_stall_pct;
    int  samples_sent;
    int  quiet_cycles;

    marching_squares_contour dut (
        .aclk(aclk), .aresetn(aresetn),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .s_valid(s_valid), .s_ready(s_ready), .s_sample_value(s_sample_value),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_start_x(m_start_x), .m_start_y(m_start_y),
        .m_end_x(m_end_x), .m_end_y(m_end_y),
        .m_segment_number(m_segment_number), .m_last_of_item(m_last_of_item)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    always @(negedge aclk) begin
        m_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            sb.check_segment({m_start_x, m_start_y, m_end_x, m_end_y,
                              m_segment_number, m_last_of_item});
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) || psel) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= 20000) begin
            $display("RESULT: ERROR");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic reg_write(logic [2:0] idx, logic [31:0] val);
        @(negedge aclk);
        psel = 1'b1; pwrite = 1'b1; penable = 1'b0;
        paddr = {idx, 2'b00}; pwdata = val;
        @(negedge aclk);
        penable = 1'b1;
        @(posedge aclk);
        sb.write_reg(idx, val);
        @(negedge aclk);
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
    endtask

    task automatic set_grid(logic [31:0] c, logic [31:0] r, logic [31:0] t,
                            logic [31:0] ox, logic [31:0] oy, logic [31:0] p);
        reg_write(msq_pkg::REG_COLUMNS, c);
        reg_write(msq_pkg::REG_ROWS, r);
        reg_write(msq_pkg::REG_THRESH, t);
        reg_write(msq_pkg::REG_ORIG_X, ox);
        reg_write(msq_pkg::REG_ORIG_Y, oy);
        reg_write(msq_pkg::REG_PITCH, p);
    endtask

    // Waits for a falling edge; returns just after the rising edge of the transfer.
    task automatic send_sample(logic signed [31:0] v);
        @(negedge aclk);
        if ($urandom_range(99) < send_idle_pct) begin
            s_valid = 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge aclk);
        end
        s_valid = 1'b1;
        s_sample_value = v;
        do @(posedge aclk); while (!s_ready);
        sb.note_sample(v);
        samples_sent++;
    endtask

    task automatic release_input();
        @(negedge aclk);
        s_valid = 1'b0;
    endtask

    task automatic drain();
        release_input();
        while (sb.pending.size() != 0) @(posedge aclk);
        repeat (160) @(posedge aclk);
    endtask

    function automatic logic signed [31:0] pick_sample();
        longint v;
        int sel;
        sel = $urandom_range(99);
        if (sel < 50) begin
            case ($urandom_range(2))
                0: v = sb.thr + ($signed($urandom_range(200)) - 100);
                1: v = sb.thr + ($signed($urandom_range(200)) - 100) * 256;
                default: v = sb.thr + ($signed($urandom_range(200)) - 100) * 65536;
            endcase
        end else if (sel < 65) begin
            case ($urandom_range(4))
                0: v = sb.thr;
                1: v = sb.thr - 1;
                2: v = -64'sd2147483648;
                3: v = 64'sd2147483647;
                default: v = 0;
            endcase
        end else begin
            v = longint'($signed($urandom));
        end
        return sb.clip32(v);
    endfunction

    task automatic send_frame();
        do send_sample(pick_sample()); while (!(sb.col_cnt == 0 && sb.row_cnt == 0));
    endtask

    task automatic send_cell(logic signed [31:0] tl, logic signed [31:0] tr,
                             logic signed [31:0] bl, logic signed [31:0] br);
        send_sample(tl);
        send_sample(tr);
        send_sample(bl);
        send_sample(br);
        drain();
    endtask

    task automatic random_grid();
        logic [31:0] c, r, t, ox, oy, p;
        c = ($urandom_range(9) == 0) ? $urandom_range(0, 40) : $urandom_range(2, 9);
        r = $urandom_range(0, 8);
        case ($urandom_range(3))
            0: t = 0;
            1: t = $urandom_range(0, 8) << 16;
            2: t = $urandom;
            default: t = ($urandom_range(1)) ? 32'h7FFFFFFF : 32'h80000000;
        endcase
        ox = ($urandom_range(3) == 0) ? $urandom : $urandom_range(0, 255) << 12;
        oy = ($urandom_range(3) == 0) ? $urandom : $urandom_range(0, 255) << 12;
        case ($urandom_range(5))
            0: p = $urandom & 32'h7FFFFFFF;
            1: p = 0;
            2: p = $urandom_range(1, 1 << 20);
            default: p = 65536;
        endcase
        set_grid(c, r, t, ox, oy, p);
    endtask

    initial begin
        sb = new();
        sb.reset_state();
        aresetn = 1'b0;
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
        s_valid = 1'b0; s_sample_value = '0; m_ready = 1'b0;
        send_idle_pct = 0; recv_stall_pct = 0; samples_sent = 0; quiet_cycles = 0;
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // Single-cell frames: each frame of four samples is one cell.
        set_grid(2, 2, 0, 0, 0, 65536);
        send_cell(-100, 300, 300, -100);
        send_cell(-300, 100, 100, -300);
        send_cell(300, -100, -100, 300);
        send_cell(100, -300, -300, 100);
        send_cell(32'sh80000000, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh80000000);
        set_grid(1, 0, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF);
        send_cell(32'sh80000000, 32'sh7FFFFFFF, 32'sh7FFFFFFE, 32'sh80000000);
        set_grid(2, 2, 32'h80000000, 32'h80000000, 32'h80000000, 0);
        send_cell(32'sh80000000, -5, 7, 32'sh80000000);

        // Shrinking the frame height part-way through a frame.
        set_grid(4, 6, 0, 0, 0, 65536);
        repeat (12) send_sample(pick_sample());
        drain();
        reg_write(msq_pkg::REG_ROWS, 2);
        reg_write(msq_pkg::REG_THRESH, 32'h00010000);
        send_frame();
        drain();

        for (int ph = 0; ph < 4 || samples_sent < 1000; ph++) begin
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 71; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 71; end
                default: begin send_idle_pct = 23; recv_stall_pct = 23; end
            endcase
            if (ph == 2) begin
                // An oversized row width is clamped; a narrower width then ends the row.
                set_grid(2047, 1, 0, 0, 0, 65536);
                repeat (40) send_sample(pick_sample());
                drain();
                reg_write(msq_pkg::REG_COLUMNS, 8);
                send_frame();
                drain();
            end
            repeat (4) begin
                random_grid();
                repeat ($urandom_range(1, 3)) send_frame();
                drain();
            end
        end

        recv_stall_pct = 0;
        drain();
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

>>> marching_squares_contour.f
design/msq_pkg.sv
design/msq_ram.sv
design/marching_squares_contour.sv
sim/marching_squares_contour_tb.sv
